/* src/button_debounce_hold_repeat_core_defines.svh */
// assertion macros for the button debounce core
// used by the files under src that check their own logic; no dependencies
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_CORE_DEFINES_SVH
`ifndef SYNTH
// checked only out of reset
`define BDHR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdhr assertion failed");
// checked at every edge, reset included
`define BDHR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bdhr assertion failed");
`else
`define BDHR_ASSERT(label, prop)
`define BDHR_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* src/bdhr_pkg.sv */
// shared types and codes for the button debounce core
// no dependencies
package bdhr_pkg;

  // event kinds
  localparam logic [1:0] KIND_PRESSED  = 2'd0;
  localparam logic [1:0] KIND_RELEASED = 2'd1;
  localparam logic [1:0] KIND_HELD     = 2'd2;
  localparam logic [1:0] KIND_REPEAT   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [2:0] REG_REPEAT_DELAY = 3'd3;
  localparam logic [2:0] REG_REPEAT_RATE  = 3'd4;

  // register reset values
  localparam logic [15:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [15:0] REPEAT_DELAY_RST = 16'd500;
  localparam logic [15:0] REPEAT_RATE_RST  = 16'd100;

  // event queue size
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic        active_level;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_rate_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pin_level;
    logic [2:0]  button_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  button;
    logic [1:0]  kind;
    logic [31:0] hold_ms;
    logic [31:0] time_ms;
    logic        last;
  } evt_t;

endpackage

/* src/button_debounce_hold_repeat_core.sv */
// top level: sample register, state evaluation, event queue, config port
// depends on bdhr_pkg, bdhr_cfg, bdhr_eval, bdhr_outq and the macro header
//
//   port group   role     fields, lowest bit first
//   in_*         sample   tdata: button_index[3] pin_level[1] now_ms[32]
//   out_*        event    tdata: event_button[3] press_dur_ms[32] event_time_ms[32];
//                         tuser: event_kind[2]; tlast: last_of_run
//   cfg_*        apb      regs at 0x0,0x4,0x8,0xc,0x10
//
// one sample a cycle while the queue has room; a sample is taken into the sample
// register, decided there, and its events are written into the event queue, whose head
// is offered on out_*. the event queue gives one word a cycle while out_tready is high,
// so samples that raise both held and repeat leave two words to drain. a registered
// sample is decided only while the queue has room for two words after this cycle's pop.
// reset is synchronous and clears all button state to released.
`include "button_debounce_hold_repeat_core_defines.svh"
module button_debounce_hold_repeat_core
  import bdhr_pkg::*;
#(
  parameter int BUTTONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // button_index[2:0], pin_level[3], now_ms[35:4]
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // event_button[2:0], press_dur_ms[34:3], event_time_ms[66:35]
  output logic [71:0] out_tdata,
  // event_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t       cfg;
  in_item_t   inq_r;
  logic       inq_valid_r;
  logic       room;
  logic       fire;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  evt_t       res0;
  evt_t       res1;
  evt_t       head;

  assign cfg_pready = 1'b1;

  bdhr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // sample register handshake
  assign fire      = inq_valid_r & room;
  assign in_tready = ~inq_valid_r | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_tready) begin
      inq_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      inq_r.button_index <= in_tdata[2:0];
      inq_r.pin_level    <= in_tdata[3];
      inq_r.now_ms       <= in_tdata[35:4];
    end
  end

  bdhr_eval #(
    .BUTTONS (BUTTONS)
  ) u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (inq_r),
    .cfg     (cfg),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  assign push_cnt = fire ? res_cnt : 2'd0;

  bdhr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  // output word packing
  assign out_tdata = {5'd0, head.time_ms, head.hold_ms, head.button};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  `BDHR_ASSERT(a_stall_holds, (inq_valid_r && !room) |=> (inq_valid_r && $stable(inq_r)))
  `BDHR_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !inq_valid_r)

endmodule

/* src/bdhr_cfg.sv */
// configuration registers behind the apb-style port
// depends on bdhr_pkg
module bdhr_cfg
  import bdhr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level    <= 1'b0;
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.long_press_ms   <= LONG_PRESS_RST;
      cfg_r.repeat_delay_ms <= REPEAT_DELAY_RST;
      cfg_r.repeat_rate_ms  <= REPEAT_RATE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ACTIVE_LEVEL: cfg_r.active_level    <= pwdata[0];
        REG_DEBOUNCE:     cfg_r.debounce_ms     <= pwdata[15:0];
        REG_LONG_PRESS:   cfg_r.long_press_ms   <= pwdata[15:0];
        REG_REPEAT_DELAY: cfg_r.repeat_delay_ms <= pwdata[15:0];
        REG_REPEAT_RATE:  cfg_r.repeat_rate_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_ACTIVE_LEVEL: prdata = {31'd0, cfg_r.active_level};
      REG_DEBOUNCE:     prdata = {16'd0, cfg_r.debounce_ms};
      REG_LONG_PRESS:   prdata = {16'd0, cfg_r.long_press_ms};
      REG_REPEAT_DELAY: prdata = {16'd0, cfg_r.repeat_delay_ms};
      REG_REPEAT_RATE:  prdata = {16'd0, cfg_r.repeat_rate_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* src/bdhr_eval.sv */
// per-button state file and the event decision for one registered sample
// depends on bdhr_pkg and the assertion macro header
`include "button_debounce_hold_repeat_core_defines.svh"
module bdhr_eval
  import bdhr_pkg::*;
#(
  parameter int BUTTONS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  input  cfg_t     cfg,
  output logic [1:0] res_cnt,
  output evt_t     res0,
  output evt_t     res1
);

  localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  logic        seen_r  [BUTTONS];
  logic [31:0] rtime_r [BUTTONS];
  logic        deb_r   [BUTTONS];
  logic [31:0] pst_r   [BUTTONS];
  logic        held_r  [BUTTONS];
  logic [31:0] lrt_r   [BUTTONS];

  logic [IW-1:0] slot;
  logic          idx_ok;
  logic          raw;
  logic          chg;
  logic [31:0]   ctime;
  logic          stable;
  logic          prev;
  logic          is_press;
  logic          is_rel;
  logic [31:0]   hold;
  logic          due_held;
  logic          due_rep;
  logic          upd;

  // lookup and compare for the current sample
  always_comb begin
    slot     = IW'(item.button_index);
    idx_ok   = (32'(item.button_index) < BUTTONS);
    raw      = (item.pin_level == cfg.active_level);
    chg      = (raw != seen_r[slot]);
    ctime    = chg ? item.now_ms : rtime_r[slot];
    stable   = ((item.now_ms - ctime) >= {16'd0, cfg.debounce_ms});
    prev     = deb_r[slot];
    is_press = raw & ~prev;
    is_rel   = ~raw & prev;
    hold     = item.now_ms - pst_r[slot];
    due_held = raw & prev & ~held_r[slot] & (hold >= {16'd0, cfg.long_press_ms});
    due_rep  = raw & prev & (hold >= {16'd0, cfg.repeat_delay_ms}) &
               ((item.now_ms - lrt_r[slot]) >= {16'd0, cfg.repeat_rate_ms});
    upd      = fire & idx_ok;
  end

  // result words
  always_comb begin
    res0.button  = item.button_index;
    res0.kind    = KIND_REPEAT;
    res0.hold_ms = hold;
    res0.time_ms = item.now_ms;
    res1.button  = item.button_index;
    res1.kind    = KIND_REPEAT;
    res1.hold_ms = hold;
    res1.time_ms = item.now_ms;
    res1.last    = 1'b1;
    res_cnt      = 2'd0;
    if (idx_ok && stable) begin
      if (is_press) begin
        res_cnt      = 2'd1;
        res0.kind    = KIND_PRESSED;
        res0.hold_ms = 32'd0;
      end else if (is_rel) begin
        res_cnt   = 2'd1;
        res0.kind = KIND_RELEASED;
      end else if (due_held) begin
        res_cnt   = due_rep ? 2'd2 : 2'd1;
        res0.kind = KIND_HELD;
      end else if (due_rep) begin
        res_cnt = 2'd1;
      end
    end
    res0.last = (res_cnt == 2'd1);
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUTTONS; i++) begin
        seen_r[i]  <= 1'b0;
        rtime_r[i] <= 32'd0;
        deb_r[i]   <= 1'b0;
        pst_r[i]   <= 32'd0;
        held_r[i]  <= 1'b0;
        lrt_r[i]   <= 32'd0;
      end
    end else if (upd) begin
      if (chg) begin
        seen_r[slot]  <= raw;
        rtime_r[slot] <= item.now_ms;
      end
      if (stable) begin
        deb_r[slot] <= raw;
        if (is_press) begin
          pst_r[slot]  <= item.now_ms;
          held_r[slot] <= 1'b0;
          lrt_r[slot]  <= item.now_ms;
        end else begin
          if (due_held) held_r[slot] <= 1'b1;
          if (due_rep)  lrt_r[slot]  <= item.now_ms;
        end
      end
    end
  end

  `BDHR_ASSERT(a_pair_order, (res_cnt == 2'd2) |-> (res0.kind == KIND_HELD && res1.kind == KIND_REPEAT))
  `BDHR_ASSERT(a_press_clears_held, (upd && stable && is_press) |=> !held_r[$past(slot)])

endmodule

/* src/bdhr_outq.sv */
// four-word event queue, takes up to two words a cycle while it has room, gives one while out_ready is high
// depends on bdhr_pkg and the assertion macro header
`include "button_debounce_hold_repeat_core_defines.svh"
module bdhr_outq
  import bdhr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  evt_t       push0,
  input  evt_t       push1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output evt_t       head
);

  evt_t           mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic [QPW-1:0] wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_nxt;
  logic [QCW-1:0] count_nxt;
  logic [QPW-1:0] wr1;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & out_ready;
  assign head      = mem_r[rd_ptr_r];
  assign wr1       = wr_ptr_r + 1'b1;
  // two free words once this cycle's pop is counted
  assign room      = (count_r <= QCW'(QDEPTH - 2)) ||
                     ((count_r == QCW'(QDEPTH - 1)) && pop);

  // pointer and fill arithmetic
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + QPW'(pop);
    count_nxt  = count_r + QCW'(push_cnt) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr1]      <= push1;
  end

  `BDHR_ASSERT(a_fill_bound, count_r <= QCW'(QDEPTH))
  `BDHR_ASSERT(a_no_overflow, (push_cnt != 2'd0) |-> room)

endmodule
